/* design/slstd_pkg.sv */
// Shared constants for the sorted list triple difference block.
// No dependencies; imported by the interfaces, the top level, the checker and the testbench.
package slstd_pkg;

    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_C = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd3;

endpackage

/* design/slstd_in_if.sv */
// Input channel: valid/ready handshake carrying one mode/value item.
// Depends on slstd_pkg.
interface slstd_in_if
    import slstd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

/* design/slstd_out_if.sv */
// Output channel: valid/ready handshake carrying one result item.
// Depends on slstd_pkg.
interface slstd_out_if
    import slstd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] kept_value;
    logic                      last;
    logic                      empty_res;
    logic                      overflowed;

    modport source (output valid, output kept_value, output last, output empty_res,
                    output overflowed, input ready);
    modport sink   (input valid, input kept_value, input last, input empty_res,
                    input overflowed, output ready);
endinterface

/* design/slstd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module slstd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/sorted_list_triple_difference_top.sv */
// Top level of the sorted list triple difference block.
// Depends on slstd_pkg, slstd_in_if, slstd_out_if and slstd_ram.
//
// Loads (mode 0..2) append one value to list A, B or C; a load into a
// full list is dropped and flags overflow. A run item (mode 3) emits
// every A value, in stored order, that does not occur in both B and C,
// then clears the counts and the overflow flag. If nothing survives, one
// item with empty_res and last set and kept_value zero is given. Lists
// need not be sorted: each A value is checked by a linear probe of B and,
// on a hit, of C through one shared equality comparator, with one read port
// per store. Each probe step passes an address state and a compare state.
// After the run item each A value passes an address and a data state and
// then its probes; a kept value also passes the end of its probe list and
// a hand-off state, and the run closes in a final state; stalls on the
// output hold the hand-off and the close. The block takes no new item
// during a run. The stores need no clearing after reset.
module sorted_list_triple_difference_top
    import slstd_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    slstd_in_if.sink     in_item,
    slstd_out_if.source  out_item
);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_A_ADDR = 9'b000000010,
        S_A_DATA = 9'b000000100,
        S_B_ADDR = 9'b000001000,
        S_B_CMP  = 9'b000010000,
        S_C_ADDR = 9'b000100000,
        S_C_CMP  = 9'b001000000,
        S_KEEP   = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] count_c_reg, count_c_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] ia_reg, ia_next;
    logic [CW-1:0] jb_reg, jb_next;
    logic [CW-1:0] jc_reg, jc_next;
    logic          pend_valid_reg, pend_valid_next;
    logic signed [VALUE_W-1:0] pend_reg, pend_next;
    logic signed [VALUE_W-1:0] x_reg, x_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_empty_reg, out_empty_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic               in_acc;
    logic               slot_free;
    logic               we_a, we_b, we_c;
    logic [VALUE_W-1:0] a_rdata, b_rdata, c_rdata;
    logic [VALUE_W-1:0] probe_data;
    logic               cmp_eq;

    assign in_acc    = in_item.valid && in_item.ready;
    assign slot_free = !out_valid_reg || out_item.ready;

    assign we_a = in_acc && (in_item.mode == MODE_LOAD_A) && (count_a_reg != FULL);
    assign we_b = in_acc && (in_item.mode == MODE_LOAD_B) && (count_b_reg != FULL);
    assign we_c = in_acc && (in_item.mode == MODE_LOAD_C) && (count_c_reg != FULL);

    slstd_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (in_item.value),
        .raddr (ia_reg[AW-1:0]),
        .rdata (a_rdata)
    );

    slstd_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (in_item.value),
        .raddr (jb_reg[AW-1:0]),
        .rdata (b_rdata)
    );

    slstd_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_c (
        .clk   (clk),
        .we    (we_c),
        .waddr (count_c_reg[AW-1:0]),
        .wdata (in_item.value),
        .raddr (jc_reg[AW-1:0]),
        .rdata (c_rdata)
    );

    // shared comparator for B and C probes
    assign probe_data = (state_reg == S_C_CMP) ? c_rdata : b_rdata;
    assign cmp_eq     = (probe_data == x_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        count_c_next    = count_c_reg;
        ovf_next        = ovf_reg;
        ia_next         = ia_reg;
        jb_next         = jb_reg;
        jc_next         = jc_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        x_next          = x_reg;
        out_valid_next  = out_valid_reg && !out_item.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_item.mode)
                        MODE_LOAD_A:
                        begin
                            if (count_a_reg == FULL) ovf_next = 1'b1;
                            else count_a_next = count_a_reg + CW'(1);
                        end
                        MODE_LOAD_B:
                        begin
                            if (count_b_reg == FULL) ovf_next = 1'b1;
                            else count_b_next = count_b_reg + CW'(1);
                        end
                        MODE_LOAD_C:
                        begin
                            if (count_c_reg == FULL) ovf_next = 1'b1;
                            else count_c_next = count_c_reg + CW'(1);
                        end
                        default:
                        begin
                            ia_next         = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_A_ADDR;
                        end
                    endcase
                end
            end
            S_A_ADDR:
            begin
                if (ia_reg == count_a_reg) state_next = S_FIN;
                else state_next = S_A_DATA;
            end
            S_A_DATA:
            begin
                x_next     = a_rdata;
                jb_next    = '0;
                state_next = S_B_ADDR;
            end
            S_B_ADDR:
            begin
                if (jb_reg == count_b_reg) state_next = S_KEEP;
                else state_next = S_B_CMP;
            end
            S_B_CMP:
            begin
                if (cmp_eq)
                begin
                    jc_next    = '0;
                    state_next = S_C_ADDR;
                end
                else
                begin
                    jb_next    = jb_reg + CW'(1);
                    state_next = S_B_ADDR;
                end
            end
            S_C_ADDR:
            begin
                if (jc_reg == count_c_reg) state_next = S_KEEP;
                else state_next = S_C_CMP;
            end
            S_C_CMP:
            begin
                if (cmp_eq)
                begin
                    ia_next    = ia_reg + CW'(1);
                    state_next = S_A_ADDR;
                end
                else
                begin
                    jc_next    = jc_reg + CW'(1);
                    state_next = S_C_ADDR;
                end
            end
            S_KEEP:
            begin
                // survivor held back one step so the final one can carry last
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = pend_reg;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                        out_ovf_next   = ovf_reg;
                    end
                    pend_next       = x_reg;
                    pend_valid_next = 1'b1;
                    ia_next         = ia_reg + CW'(1);
                    state_next      = S_A_ADDR;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = pend_valid_reg ? pend_reg : '0;
                    out_last_next  = 1'b1;
                    out_empty_next = !pend_valid_reg;
                    out_ovf_next   = ovf_reg;
                    count_a_next   = '0;
                    count_b_next   = '0;
                    count_c_next   = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            count_c_reg    <= '0;
            ovf_reg        <= 1'b0;
            ia_reg         <= '0;
            jb_reg         <= '0;
            jc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            count_c_reg    <= count_c_next;
            ovf_reg        <= ovf_next;
            ia_reg         <= ia_next;
            jb_reg         <= jb_next;
            jc_reg         <= jc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        x_reg         <= x_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign in_item.ready       = (state_reg == S_IDLE);
    assign out_item.valid      = out_valid_reg;
    assign out_item.kept_value = out_value_reg;
    assign out_item.last       = out_last_reg;
    assign out_item.empty_res  = out_empty_reg;
    assign out_item.overflowed = out_ovf_reg;

    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_item.mode == MODE_RUN) |=> !in_item.ready)
        else $error("input taken right after a run item");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_a_reg <= FULL) && ((state_reg == S_IDLE) || (ia_reg <= count_a_reg)))
        else $error("A walk index beyond A count");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_last_reg && out_value_reg == '0))
        else $error("empty result not final or not zero");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && slot_free) |=>
            (count_a_reg == '0 && count_b_reg == '0 && count_c_reg == '0 && !ovf_reg
             && out_valid_reg && out_last_reg))
        else $error("run end did not clear counts or post final result");
endmodule

/* verif/slstd_difference_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted list triple difference block: watches both channels,
// keeps its own copy of the three lists and compares every result item.
// Depends on slstd_pkg, slstd_in_if and slstd_out_if.
module slstd_difference_checker
    import slstd_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    slstd_in_if   in_ch,
    slstd_out_if  out_ch,
    output int    mismatches,
    output int    pending
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] kept_value;
        logic                      last;
        logic                      empty_res;
        logic                      overflowed;
    } kept_item_t;

    kept_item_t                kept_q[$];
    kept_item_t                got;
    logic signed [VALUE_W-1:0] lists [3][LIST_DEPTH];
    int unsigned               list_len [3];
    logic                      overflow_seen;

    function automatic bit in_list(input int which, input logic signed [VALUE_W-1:0] x);
        bit hit;
        hit = 1'b0;
        for (int j = 0; j < list_len[which]; j++) begin
            if (lists[which][j] == x)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void predict_item(input logic [MODE_W-1:0] mode,
                                         input logic signed [VALUE_W-1:0] value);
        kept_item_t r;
        int         kept;
        kept = 0;
        case (mode)
            MODE_LOAD_A, MODE_LOAD_B, MODE_LOAD_C:
            begin
                if (list_len[mode] >= LIST_DEPTH) begin
                    overflow_seen = 1'b1;
                end else begin
                    lists[mode][list_len[mode]] = value;
                    list_len[mode]++;
                end
            end
            MODE_RUN:
            begin
                for (int i = 0; i < list_len[MODE_LOAD_A]; i++) begin
                    r.kept_value = lists[MODE_LOAD_A][i];
                    if (!(in_list(MODE_LOAD_B, r.kept_value) &&
                          in_list(MODE_LOAD_C, r.kept_value))) begin
                        r.last       = 1'b0;
                        r.empty_res  = 1'b0;
                        r.overflowed = overflow_seen;
                        kept_q.push_back(r);
                        kept++;
                    end
                end
                if (kept == 0) begin
                    r.kept_value = '0;
                    r.last       = 1'b1;
                    r.empty_res  = 1'b1;
                    r.overflowed = overflow_seen;
                    kept_q.push_back(r);
                end else begin
                    kept_q[kept_q.size()-1].last = 1'b1;
                end
                for (int k = 0; k < 3; k++)
                    list_len[k] = 0;
                overflow_seen = 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kept_q.delete();
            for (int k = 0; k < 3; k++)
                list_len[k] = 0;
            overflow_seen = 1'b0;
            mismatches    = 0;
            pending       = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (kept_q.size() == 0) begin
                    $error("result item with none expected: kept_value %0d",
                           out_ch.kept_value);
                    mismatches++;
                end else begin
                    got = kept_q.pop_front();
                    if (out_ch.kept_value !== got.kept_value) begin
                        $error("kept_value expected %0d actual %0d",
                               got.kept_value, out_ch.kept_value);
                        mismatches++;
                    end
                    if (out_ch.last !== got.last) begin
                        $error("last expected %0b actual %0b", got.last, out_ch.last);
                        mismatches++;
                    end
                    if (out_ch.empty_res !== got.empty_res) begin
                        $error("empty_res expected %0b actual %0b",
                               got.empty_res, out_ch.empty_res);
                        mismatches++;
                    end
                    if (out_ch.overflowed !== got.overflowed) begin
                        $error("overflowed expected %0b actual %0b",
                               got.overflowed, out_ch.overflowed);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.mode, in_ch.value);
            pending = kept_q.size();
        end
    end

endmodule

/* verif/tb_sorted_list_triple_difference_top.sv */
`timescale 1ns / 1ps
// Testbench top for sorted_list_triple_difference_top: drives list loads and
// runs with bursty input and a stalling receiver, and gives the verdict.
// Depends on slstd_pkg, the channel interfaces, the block and the checker.
module tb_sorted_list_triple_difference_top;
    import slstd_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int IDLE_LIMIT  = 200000;
    localparam int ITEM_TARGET = 180;

    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;
    localparam logic [MODE_W-1:0] LOAD_MODES [3] = '{MODE_LOAD_A, MODE_LOAD_B, MODE_LOAD_C};

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   items_sent;
    int   burst_left;
    int   idle_cycles;

    slstd_in_if  in_item();
    slstd_out_if out_item();

    sorted_list_triple_difference_top #(.LIST_DEPTH(LIST_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item)
    );

    slstd_difference_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_item),
        .out_ch     (out_item),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sorted_list_triple_difference_top test failed");
                $finish;
            end
        end
    end

    // receiver: alternates between always ready, coin flips and duty cycles
    initial
    begin : receiver
        int style;
        int phase_left;
        int period;
        int duty;
        int cnt;
        out_item.ready = 1'b0;
        style      = 0;
        phase_left = 0;
        period     = 2;
        duty       = 1;
        cnt        = 0;
        forever begin
            @(negedge clk);
            if (phase_left == 0) begin
                style      = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 80);
                period     = $urandom_range(2, 9);
                duty       = $urandom_range(1, period - 1);
            end
            phase_left--;
            cnt++;
            case (style)
                0:       out_item.ready <= 1'b1;
                1:       out_item.ready <= 1'($urandom_range(0, 1));
                default: out_item.ready <= ((cnt % period) < duty);
            endcase
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [VALUE_W-1:0] value);
        int gap;
        @(negedge clk);
        in_item.valid <= 1'b1;
        in_item.mode  <= mode;
        in_item.value <= value;
        @(posedge clk);
        while (!in_item.ready)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            @(negedge clk);
            in_item.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        int                        m;
        int                        kind;
        int                        left [3];
        logic signed [VALUE_W-1:0] next_v [3];
        logic signed [VALUE_W-1:0] base;

        rst_n         = 1'b0;
        in_item.valid = 1'b0;
        in_item.mode  = MODE_LOAD_A;
        in_item.value = '0;
        items_sent    = 0;
        burst_left    = $urandom_range(1, 30);
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // run with all lists empty
        send_item(MODE_RUN, '1);
        // extremes; only the largest value lies in both B and C
        send_item(MODE_LOAD_A, V_MIN);
        send_item(MODE_LOAD_A, -1);
        send_item(MODE_LOAD_A, 0);
        send_item(MODE_LOAD_A, V_MAX);
        send_item(MODE_LOAD_B, -1);
        send_item(MODE_LOAD_B, V_MAX);
        send_item(MODE_LOAD_C, V_MAX);
        send_item(MODE_LOAD_C, 5);
        send_item(MODE_RUN, 0);
        // duplicates in A all removed
        send_item(MODE_LOAD_A, 3);
        send_item(MODE_LOAD_A, 3);
        send_item(MODE_LOAD_A, 3);
        send_item(MODE_LOAD_A, 7);
        send_item(MODE_LOAD_B, 3);
        send_item(MODE_LOAD_C, 3);
        send_item(MODE_LOAD_C, 3);
        send_item(MODE_RUN, V_MIN);
        // empty intersection keeps A whole
        send_item(MODE_LOAD_A, 1);
        send_item(MODE_LOAD_A, 2);
        send_item(MODE_LOAD_B, 1);
        send_item(MODE_LOAD_C, 2);
        send_item(MODE_RUN, V_MAX);
        // every A value removed
        send_item(MODE_LOAD_A, 9);
        send_item(MODE_LOAD_B, 9);
        send_item(MODE_LOAD_C, 9);
        send_item(MODE_RUN, 0);

        // full list A: drops set overflow, 64 results
        base = $urandom();
        repeat (LIST_DEPTH + 3) begin
            send_item(MODE_LOAD_A, base);
            base += $urandom_range(0, 3);
        end
        send_item(MODE_RUN, $urandom());

        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                if ($urandom_range(0, 3) == 0)
                    base = $urandom_range(0, 8) - 4;
                else
                    base = $urandom();
                for (int k = 0; k < 3; k++)
                    next_v[k] = base + $urandom_range(0, 3);
                left[0] = $urandom_range(0, 8);
                left[1] = $urandom_range(0, 6);
                left[2] = $urandom_range(0, 6);
                while (left[0] + left[1] + left[2] > 0) begin
                    m = $urandom_range(0, 2);
                    if (left[m] > 0) begin
                        send_item(LOAD_MODES[m], next_v[m]);
                        next_v[m] += $urandom_range(0, 2);
                        left[m]--;
                    end
                end
                send_item(MODE_RUN, $urandom());
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(MODE_W'($urandom_range(0, 3)), $urandom());
            end
        end
        send_item(MODE_RUN, $urandom());

        @(negedge clk);
        in_item.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
        if (mismatches == 0)
            $display("sorted_list_triple_difference_top test passed");
        else
            $display("sorted_list_triple_difference_top test failed");
        $finish;
    end

endmodule
